/* rtl/prm_pkg.sv */
// Package for the pulse rate meter: field widths, word layouts, level codes
// and the sequencer state type. Used by every module of the block.
package prm_pkg;

   localparam int SAMPLE_W       = 12;
   localparam int TIME_W         = 32;
   localparam int RATE_W         = 16;
   localparam int IDX_W          = 4;
   localparam int CLASS_W        = 2;
   localparam int RATE_NUMERATOR = 60000;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 2;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd1200;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE      = 12'd4095;

   localparam logic [CLASS_W-1:0] LVL_BELOW = 2'd0;
   localparam logic [CLASS_W-1:0] LVL_ABOVE = 2'd1;
   localparam logic [CLASS_W-1:0] LVL_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE_START,
      ST_RATE_WAIT,
      ST_SUM,
      ST_MEAN,
      ST_OUT
   } state_type;

endpackage

/* rtl/prm_divider.sv */
// Restoring divider for the pulse rate meter, one quotient bit per cycle.
// Depends on prm_pkg for the divisor width.
module prm_divider
   import prm_pkg::*;
#(
   parameter int DVD_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [TIME_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVD_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = ({{(TIME_W-DVD_W-1){1'b0}}, trial} >= dvs_ff);

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DVD_W'(trial - dvs_ff[DVD_W:0]);
         end else begin
            rem_in = trial[DVD_W-1:0];
         end
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/pulse_rate_meter.sv */
// Pulse rate meter: beat detection, period, rate, mean over a group of beats.
// A sample without a beat goes straight to the output; a beat first runs the rate
// division (DVD_W is 16), and the beat that closes a group also sums the stored rates.
// Throughput: one word at a time, set by the one-bit-per-cycle divider and output stalls.
// Reset (synchronous): threshold 1200, last beat time 1, beat index and mean cleared.
module pulse_rate_meter
   import prm_pkg::*;
#(
   parameter int AVG_BEATS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [SAMPLE_W-1:0]   csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sample[11:0], time_ms[43:12], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // period_ms[31:0], rate_bpm[47:32], mean_bpm[63:48], level_class[65:64], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // beat[0], mean_updated[1]
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int SUM_W   = $clog2(AVG_BEATS * RATE_NUMERATOR + 1);
   localparam int DVD_W   = RATE_W;
   localparam int SI_W    = (AVG_BEATS > 2) ? $clog2(AVG_BEATS) : 1;
   localparam int MUL_W   = SUM_W + 1;
   localparam int PROD_W  = SUM_W + MUL_W;
   localparam int MEAN_SH = SUM_W + $clog2(AVG_BEATS);
   localparam logic [MUL_W-1:0] MEAN_MUL =
      MUL_W'(((1 << MEAN_SH) + AVG_BEATS - 1) / AVG_BEATS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_BEATS - 1);

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] thr_ff, thr_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [IDX_W-1:0]    bidx_ff, bidx_in;
   logic [RATE_W-1:0]   mean_ff, mean_in;
   logic [TIME_W-1:0]   period_ff, period_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                beat_ff, beat_in;
   logic                upd_ff, upd_in;
   logic [CLASS_W-1:0]  cls_ff, cls_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SI_W-1:0]     scnt_ff, scnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic [RATE_W-1:0]   rate_store_ff [AVG_BEATS];

   logic [SAMPLE_W-1:0] s;
   logic [TIME_W-1:0]   t;
   logic [TIME_W-1:0]   period_raw;
   logic                is_beat;
   logic [IDX_W-1:0]    idx;
   logic                group_end;
   logic                out_free;
   logic                store_we;
   logic                div_start;
   logic                div_busy;
   logic                div_done;
   logic [DVD_W-1:0]    div_dvd;
   logic [TIME_W-1:0]   div_dvs;
   logic [DVD_W-1:0]    div_q;
   logic [PROD_W-1:0]   mean_prod;

   assign s          = req_tdata[SAMPLE_W-1:0];
   assign t          = req_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
   assign period_raw = t - last_ff;
   assign is_beat    = (s >= thr_ff) && (prev_ff <= thr_ff);
   assign idx        = ({1'b0, bidx_ff} >= (IDX_W + 1)'(AVG_BEATS)) ? LAST_IDX : bidx_ff;
   assign group_end  = (idx == LAST_IDX);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_dvd    = DVD_W'(RATE_NUMERATOR);
   assign div_dvs    = period_ff;
   // sum / AVG_BEATS by reciprocal multiply, exact over the whole sum range
   assign mean_prod  = PROD_W'(sum_ff) * PROD_W'(MEAN_MUL);

   prm_divider #(
      .DVD_W(DVD_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dvd),
      .divisor (div_dvs),
      .busy    (div_busy),
      .done    (div_done),
      .quotient(div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = is_beat ? ST_RATE_START : ST_OUT;
            end
         end
         ST_RATE_START: state_in = ST_RATE_WAIT;
         ST_RATE_WAIT: begin
            if (div_done) begin
               state_in = group_end ? ST_SUM : ST_OUT;
            end
         end
         ST_SUM: begin
            if (scnt_ff == SI_W'(AVG_BEATS - 1)) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      store_we   = 1'b0;
      unique case (state_ff)
         ST_IDLE:       req_tready = 1'b1;
         ST_RATE_START: div_start  = 1'b1;
         ST_RATE_WAIT:  store_we   = div_done;
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      thr_in       = csr_we ? csr_wdata : thr_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      bidx_in      = bidx_ff;
      mean_in      = mean_ff;
      period_in    = period_ff;
      rate_in      = rate_ff;
      beat_in      = beat_ff;
      upd_in       = upd_ff;
      cls_in       = cls_ff;
      sum_in       = sum_ff;
      scnt_in      = scnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               prev_in   = s;
               beat_in   = is_beat;
               upd_in    = 1'b0;
               rate_in   = '0;
               period_in = '0;
               if (s == FULL_SCALE) begin
                  cls_in = LVL_FULL;
               end else if (s >= thr_ff) begin
                  cls_in = LVL_ABOVE;
               end else begin
                  cls_in = LVL_BELOW;
               end
               if (is_beat) begin
                  last_in   = t;
                  period_in = (period_raw == '0) ? TIME_W'(1) : period_raw;
               end
            end
         end
         ST_RATE_WAIT: begin
            if (div_done) begin
               rate_in = div_q[RATE_W-1:0];
               if (group_end) begin
                  bidx_in = '0;
                  sum_in  = '0;
                  scnt_in = '0;
               end else begin
                  bidx_in = idx + 1'b1;
               end
            end
         end
         ST_SUM: begin
            sum_in  = sum_ff + SUM_W'(rate_store_ff[scnt_ff]);
            scnt_in = scnt_ff + 1'b1;
         end
         ST_MEAN: begin
            mean_in = mean_prod[MEAN_SH +: RATE_W];
            upd_in  = 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, cls_ff, mean_ff, rate_ff, period_ff};
               rsp_user_in  = {upd_ff, beat_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THRESHOLD_RESET;
         prev_ff      <= '0;
         last_ff      <= TIME_W'(1);
         bidx_ff      <= '0;
         mean_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         bidx_ff      <= bidx_in;
         mean_ff      <= mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      period_ff   <= period_in;
      rate_ff     <= rate_in;
      beat_ff     <= beat_in;
      upd_ff      <= upd_in;
      cls_ff      <= cls_in;
      sum_ff      <= sum_in;
      scnt_ff     <= scnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         rate_store_ff[idx[SI_W-1:0]] <= div_q[RATE_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTH
   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy)
      else $error("input accepted while divider busy");

   a_mean_only_on_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("mean update without a beat");

   a_no_beat_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[47:0] == 48'd0))
      else $error("period or rate nonzero without a beat");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, bidx_ff} < (IDX_W + 1)'(AVG_BEATS)))
      else $error("beat index out of range");
`endif

endmodule

/* dv/pulse_rate_meter_tb.sv */
// Self-checking testbench for pulse_rate_meter: beat detection, period, rate,
// ten-beat mean and level class, checked against an in-bench predictor.
// Depends on rtl/prm_pkg.sv, rtl/prm_divider.sv and rtl/pulse_rate_meter.sv.
module pulse_rate_meter_tb
   import prm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AVG_BEATS      = 10;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int HOLD_CYCLES    = 400;
   localparam logic [TIME_W-1:0] RATE_NUM = RATE_NUMERATOR;

   typedef struct {
      logic               beat;
      logic [TIME_W-1:0]  period_ms;
      logic [RATE_W-1:0]  rate_bpm;
      logic [RATE_W-1:0]  mean_bpm;
      logic               mean_updated;
      logic [CLASS_W-1:0] level_class;
   } beat_report_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [SAMPLE_W-1:0]   csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // sample, time_ms, zero fill
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // period_ms, rate_bpm, mean_bpm, level_class
   logic [RSP_USER_W-1:0] rsp_tuser;        // beat, mean_updated

   // predictor state
   logic [SAMPLE_W-1:0] thr_level    = THRESHOLD_RESET;
   logic [SAMPLE_W-1:0] last_sample  = '0;
   logic [TIME_W-1:0]   last_beat_ms = 1;
   int unsigned         slot         = 0;
   logic [RATE_W-1:0]   rate_hist [AVG_BEATS] = '{default: '0};
   logic [RATE_W-1:0]   avg_rate     = '0;
   beat_report_type     pending_reports [$];

   int unsigned       tx_idle_pct  = 11;
   int unsigned       rx_idle_pct  = 63;
   int unsigned       fail_count   = 0;
   int unsigned       stall_cycles = 0;
   int unsigned       hold_left    = 0;
   int unsigned       hold_req     = 0;
   int unsigned       hold_seen    = 0;
   logic [TIME_W-1:0] stamp_ms     = 32'd10000;

   pulse_rate_meter #(.AVG_BEATS(AVG_BEATS)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic beat_report_type predict_reading(logic [SAMPLE_W-1:0] s,
                                                       logic [TIME_W-1:0] t);
      beat_report_type r;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] sum;
      r = '{default: '0};
      if (s >= thr_level && last_sample <= thr_level) begin
         span = t - last_beat_ms;
         last_beat_ms = t;
         if (span == 0) span = 1;
         r.beat      = 1'b1;
         r.period_ms = span;
         r.rate_bpm  = RATE_W'(RATE_NUM / span);
         rate_hist[slot] = r.rate_bpm;
         if (slot == AVG_BEATS - 1) begin
            sum = '0;
            foreach (rate_hist[i]) sum += TIME_W'(rate_hist[i]);
            avg_rate = RATE_W'(sum / AVG_BEATS);
            r.mean_updated = 1'b1;
            slot = 0;
         end else begin
            slot++;
         end
      end
      r.mean_bpm = avg_rate;
      if (s == FULL_SCALE) r.level_class = LVL_FULL;
      else if (s >= thr_level) r.level_class = LVL_ABOVE;
      else r.level_class = LVL_BELOW;
      last_sample = s;
      return r;
   endfunction

   task automatic send_reading(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - SAMPLE_W - TIME_W){1'b0}}, t, s};
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(predict_reading(s, t));
   endtask

   // only while the block is idle: every expected word already received
   task automatic set_threshold(input logic [SAMPLE_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      thr_level = value;
   endtask

   task automatic compare_field(input string field, input logic [TIME_W-1:0] want,
                                input logic [TIME_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      beat_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h %h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("beat", TIME_W'(want.beat), TIME_W'(rsp_tuser[0]));
            compare_field("mean_updated", TIME_W'(want.mean_updated),
                          TIME_W'(rsp_tuser[1]));
            compare_field("period_ms", want.period_ms, rsp_tdata[TIME_W-1:0]);
            compare_field("rate_bpm", TIME_W'(want.rate_bpm),
                          TIME_W'(rsp_tdata[TIME_W +: RATE_W]));
            compare_field("mean_bpm", TIME_W'(want.mean_bpm),
                          TIME_W'(rsp_tdata[TIME_W+RATE_W +: RATE_W]));
            compare_field("level_class", TIME_W'(want.level_class),
                          TIME_W'(rsp_tdata[TIME_W+2*RATE_W +: CLASS_W]));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("pulse_rate_meter_tb: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_beat_detection();
      tx_idle_pct = 11;
      rx_idle_pct = 63;
      send_reading(12'd1200, 32'd1);            // first beat, zero period
      send_reading(FULL_SCALE, 32'd61);
      send_reading(12'd0, 32'd62);
      send_reading(12'd1199, 32'd63);
      send_reading(12'd1200, 32'd800);
      send_reading(12'd1201, 32'd801);          // previous sample equal to threshold
      send_reading(FULL_SCALE, 32'd802);
      send_reading(12'd0, 32'hFFFF_FF00);
      send_reading(12'd3000, 32'hFFFF_FFF0);    // long period, rate 0
      send_reading(12'd0, 32'hFFFF_FFFF);
      send_reading(12'd3000, 32'h0000_0020);    // timestamp wrap
      send_reading(12'd0, 32'h0000_0020);
      send_reading(12'd3000, 32'h0000_0020);    // zero period
      send_reading(12'd0, 32'd1300);
      send_reading(12'd2500, 32'd1800);
      send_reading(12'd0, 32'd1900);
      send_reading(12'd2500, 32'd2300);
      send_reading(12'd0, 32'd2400);
      send_reading(12'd2500, 32'd2900);         // closes the group, mean update
   endtask

   task automatic test_threshold_extremes();
      set_threshold('0);
      send_reading(12'd0, 32'd5000);
      send_reading(12'd0, 32'd5001);
      send_reading(12'd7, 32'd5002);
      send_reading(12'd7, 32'd5003);
      set_threshold(FULL_SCALE);
      send_reading(FULL_SCALE, 32'd5100);
      send_reading(FULL_SCALE, 32'd5100);
      send_reading(12'd4094, 32'd5101);
      set_threshold(THRESHOLD_RESET);
   endtask

   task automatic test_output_stall();
      int unsigned n;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_req++;
      for (n = 0; n < 30; n++) begin
         stamp_ms += $urandom_range(1, 400);
         send_reading(n[0] ? SAMPLE_W'($urandom_range(4095, 1200)) : 12'd0, stamp_ms);
      end
   endtask

   task automatic test_random_rhythm(input int unsigned n_items, input int unsigned tx_pct,
                                     input int unsigned rx_pct);
      int unsigned sent;
      int unsigned run_left;
      int unsigned pick;
      logic rising;
      logic [SAMPLE_W-1:0] level;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      rising = 1'b0;
      run_left = 0;
      for (sent = 0; sent < n_items; sent++) begin
         if (sent % 100 == 0) begin
            case ($urandom_range(4))
               0: set_threshold('0);
               1: set_threshold(FULL_SCALE);
               2: set_threshold(THRESHOLD_RESET);
               default: set_threshold(SAMPLE_W'($urandom_range(4095)));
            endcase
         end
         pick = $urandom_range(99);
         if (pick < 4) stamp_ms = $urandom();
         else if (pick >= 9) stamp_ms += $urandom_range(1, 60);
         if (run_left == 0) begin
            rising = !rising;
            run_left = $urandom_range(1, 4);
         end
         run_left--;
         pick = $urandom_range(99);
         if (pick < 10) level = SAMPLE_W'($urandom_range(4095));
         else if (!rising) level = SAMPLE_W'($urandom_range(thr_level, 0));
         else if (pick < 20) level = FULL_SCALE;
         else level = SAMPLE_W'($urandom_range(4095, thr_level));
         send_reading(level, stamp_ms);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_beat_detection();
      test_threshold_extremes();
      test_output_stall();
      test_random_rhythm(500, 11, 63);
      test_random_rhythm(500, 63, 11);
      test_random_rhythm(500, 0, 0);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("pulse_rate_meter_tb: PASS");
      else $display("pulse_rate_meter_tb: FAIL");
      $finish;
   end

endmodule
